// ----- rtl/stair_light_sequencer_defines.svh -----
`ifndef STAIR_LIGHT_SEQUENCER_DEFINES_SVH
`define STAIR_LIGHT_SEQUENCER_DEFINES_SVH

// concurrent check on i_clk, off while i_rst_n is low
`define STL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// same-cycle implication
`define STL_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    `STL_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ----- rtl/stl_pkg.sv -----
package stl_pkg;

    typedef logic [2:0]  t_cmd;
    typedef logic [1:0]  t_cat;
    typedef logic [31:0] t_ms;
    typedef logic [0:0]  t_cfg_idx;

    localparam t_cmd CMD_TICK      = 3'd0;
    localparam t_cmd CMD_FORCE_UP  = 3'd1;
    localparam t_cmd CMD_FORCE_DN  = 3'd2;
    localparam t_cmd CMD_FORCE_ALL = 3'd3;
    localparam t_cmd CMD_FORCE_OFF = 3'd4;

    localparam t_cat CAT_UP   = 2'd0;
    localparam t_cat CAT_DOWN = 2'd1;
    localparam t_cat CAT_FULL = 2'd2;

    localparam t_cfg_idx CFG_OFF_DELAY = 1'b0;
    localparam t_cfg_idx CFG_PASSAGE   = 1'b1;

    localparam t_ms OFF_DELAY_RST = 32'd30000;
    localparam t_ms PASSAGE_RST   = 32'd5000;
    localparam t_ms MS_MAX        = 32'hFFFF_FFFF;

    typedef struct packed {
        t_ms off_delay_ms;
        t_ms passage_window_ms;
    } t_cfg;

    typedef struct packed {
        logic lights_on;
        t_cat direction;
        logic action_fired;
    } t_result;

endpackage

// ----- rtl/stl_cfg_regs.sv -----
module stl_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  stl_pkg::t_cfg_idx i_index,
    input  stl_pkg::t_ms      i_data,
    output stl_pkg::t_cfg     o_cfg
);

    stl_pkg::t_cfg r_cfg;
    stl_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            case (i_index)
                stl_pkg::CFG_OFF_DELAY: n_cfg.off_delay_ms      = i_data;
                stl_pkg::CFG_PASSAGE:   n_cfg.passage_window_ms = i_data;
                default:                n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.off_delay_ms      <= stl_pkg::OFF_DELAY_RST;
            r_cfg.passage_window_ms <= stl_pkg::PASSAGE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/stl_step.sv -----
module stl_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  stl_pkg::t_cmd     i_command,
    input  logic              i_bottom,
    input  logic              i_top,
    input  stl_pkg::t_cfg     i_cfg,
    output stl_pkg::t_result  o_result
);

    logic          r_on,      n_on;
    stl_pkg::t_cat r_cat,     n_cat;
    stl_pkg::t_ms  r_elapsed, n_elapsed;
    logic          r_prev_b,  n_prev_b;
    logic          r_prev_t,  n_prev_t;
    logic          fired;
    logic          bot_edge;
    logic          top_edge;
    stl_pkg::t_ms  timeout;
    logic          in_window;

    assign bot_edge  = i_bottom & ~r_prev_b;
    assign top_edge  = i_top & ~r_prev_t;
    assign timeout   = (r_elapsed == stl_pkg::MS_MAX) ? r_elapsed : r_elapsed + 32'd1;
    assign in_window = timeout < i_cfg.passage_window_ms;

    always_comb begin
        n_on      = r_on;
        n_cat     = r_cat;
        n_elapsed = r_elapsed;
        n_prev_b  = r_prev_b;
        n_prev_t  = r_prev_t;
        fired     = 1'b0;
        case (i_command)
            stl_pkg::CMD_TICK: begin
                n_prev_b  = i_bottom;
                n_prev_t  = i_top;
                n_elapsed = timeout;
                if (!r_on) begin
                    if (bot_edge) begin
                        n_on  = 1'b1;
                        n_cat = stl_pkg::CAT_UP;
                        fired = 1'b1;
                    end else if (top_edge) begin
                        n_on  = 1'b1;
                        n_cat = stl_pkg::CAT_DOWN;
                        fired = 1'b1;
                    end
                end else if (timeout > i_cfg.off_delay_ms) begin
                    n_on  = 1'b0;
                    fired = 1'b1;
                end else if (r_cat == stl_pkg::CAT_DOWN && bot_edge) begin
                    n_on  = in_window;
                    n_cat = in_window ? stl_pkg::CAT_FULL : stl_pkg::CAT_DOWN;
                    fired = 1'b1;
                end else if (r_cat == stl_pkg::CAT_UP && top_edge) begin
                    n_on  = in_window;
                    n_cat = in_window ? stl_pkg::CAT_FULL : stl_pkg::CAT_UP;
                    fired = 1'b1;
                end else if (i_bottom && r_cat inside {stl_pkg::CAT_FULL, stl_pkg::CAT_UP}) begin
                    n_elapsed = '0;
                end else if (i_top && r_cat inside {stl_pkg::CAT_FULL, stl_pkg::CAT_DOWN}) begin
                    n_elapsed = '0;
                end
            end
            stl_pkg::CMD_FORCE_UP: begin
                n_on  = 1'b1;
                n_cat = stl_pkg::CAT_UP;
                fired = 1'b1;
            end
            stl_pkg::CMD_FORCE_DN: begin
                n_on  = 1'b1;
                n_cat = stl_pkg::CAT_DOWN;
                fired = 1'b1;
            end
            stl_pkg::CMD_FORCE_ALL: begin
                n_on  = 1'b1;
                n_cat = stl_pkg::CAT_FULL;
                fired = 1'b1;
            end
            stl_pkg::CMD_FORCE_OFF: begin
                n_on  = 1'b0;
                n_cat = stl_pkg::CAT_FULL;
                fired = 1'b1;
            end
            default: begin
                fired = 1'b0;
            end
        endcase
        // every action restarts the timer
        if (fired) begin
            n_elapsed = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on      <= 1'b0;
            r_cat     <= stl_pkg::CAT_FULL;
            r_elapsed <= '0;
            r_prev_b  <= 1'b0;
            r_prev_t  <= 1'b0;
        end else if (i_fire) begin
            r_on      <= n_on;
            r_cat     <= n_cat;
            r_elapsed <= n_elapsed;
            r_prev_b  <= n_prev_b;
            r_prev_t  <= n_prev_t;
        end
    end

    assign o_result.lights_on    = n_on;
    assign o_result.direction    = n_cat;
    assign o_result.action_fired = fired;

endmodule

// ----- rtl/stair_light_sequencer.sv -----
// stair light sequencer
// input channel: i_in_valid / o_in_stall with i_in_command, i_in_bottom_sensor and
//   i_in_top_sensor; one item per millisecond tick or manual command
// output channel: o_out_valid / i_out_stall with o_out_lights_on, o_out_direction
//   and o_out_action_fired; exactly one result per item, in order
// config channel: i_cfg_valid / o_cfg_ready, index 0 off delay, index 1 passage
//   window; always ready, write only while the block is idle
// path: an input transfer fills the input register, and its result is written into
//   the result register once the output is free, from where it transfers out
// throughput: one item per cycle unless stalled; the state update is one increment,
//   three 32-bit compares and edge logic between the input and result registers
// stall: a stalled result holds; one more item waits in the input register,
//   after which o_in_stall follows i_out_stall
// reset: synchronous, active low; lights off, direction full, timer and sensor
//   history cleared, off delay 30000 ms, passage window 5000 ms
module stair_light_sequencer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  stl_pkg::t_cmd         i_in_command,
    input  logic                  i_in_bottom_sensor,
    input  logic                  i_in_top_sensor,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_out_lights_on,
    output stl_pkg::t_cat         o_out_direction,
    output logic                  o_out_action_fired,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  stl_pkg::t_cfg_idx     i_cfg_index,
    input  stl_pkg::t_ms          i_cfg_data
);

    logic             r_in_valid;
    stl_pkg::t_cmd    r_cmd;
    logic             r_bottom;
    logic             r_top;
    logic             r_out_valid;
    stl_pkg::t_result r_result;
    stl_pkg::t_result step_result;
    stl_pkg::t_cfg    cfg;
    logic             out_free;
    logic             move;
    logic             in_take;

    assign out_free = ~r_out_valid | ~i_out_stall;
    assign move     = r_in_valid & out_free;
    assign in_take  = i_in_valid & ~o_in_stall;

    assign o_in_stall  = r_in_valid & ~out_free;
    assign o_cfg_ready = 1'b1;

    stl_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid & o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    stl_step u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (move),
        .i_command (r_cmd),
        .i_bottom  (r_bottom),
        .i_top     (r_top),
        .i_cfg     (cfg),
        .o_result  (step_result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd    <= i_in_command;
            r_bottom <= i_in_bottom_sensor;
            r_top    <= i_in_top_sensor;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (~i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_result <= step_result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_lights_on    = r_result.lights_on;
    assign o_out_direction    = r_result.direction;
    assign o_out_action_fired = r_result.action_fired;

endmodule

// ----- rtl/stl_checker.sv -----
`include "stair_light_sequencer_defines.svh"

module stl_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              o_in_stall,
    input  logic              o_out_valid,
    input  logic              i_out_stall,
    input  logic              o_out_lights_on,
    input  stl_pkg::t_cat     o_out_direction,
    input  logic              o_out_action_fired
);

    stl_pkg::t_result out_now;
    logic             out_held;

    assign out_now  = {o_out_lights_on, o_out_direction, o_out_action_fired};
    assign out_held = o_out_valid && i_out_stall;

    // no result comes out right after reset
    `STL_ASSERT(a_no_out_after_reset, $past(!i_rst_n) |-> !o_out_valid, "result after reset")

    // the input side only stalls behind a stalled result
    `STL_ASSERT_IMPLIES(a_stall_cause, o_in_stall, o_out_valid && i_out_stall, "spurious stall")

    // direction is never the unused code
    `STL_ASSERT_IMPLIES(a_dir_legal, o_out_valid, o_out_direction <= stl_pkg::CAT_FULL, "bad direction")

    // a stalled result holds
    `STL_ASSERT(a_out_hold, out_held |=> o_out_valid && $stable(out_now), "held result changed")

endmodule

bind stair_light_sequencer stl_checker u_stl_checker (.*);

// ----- dv/stair_light_sequencer_tb.sv -----
`timescale 1ns / 100ps

module stair_light_sequencer_tb;

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned PHASE_ITEMS = 145;
    localparam int unsigned LONG_HOLD   = 300;

    class light_scoreboard;
        stl_pkg::t_ms     off_delay;
        stl_pkg::t_ms     passage;
        logic             lit;
        stl_pkg::t_cat    cat;
        stl_pkg::t_ms     elapsed;
        logic             prev_bot;
        logic             prev_top;
        stl_pkg::t_result pending[$];
        int               errors;

        function new();
            off_delay = stl_pkg::OFF_DELAY_RST;
            passage   = stl_pkg::PASSAGE_RST;
            lit       = 1'b0;
            cat       = stl_pkg::CAT_FULL;
            elapsed   = '0;
            prev_bot  = 1'b0;
            prev_top  = 1'b0;
            errors    = 0;
        endfunction

        function void set_reg(stl_pkg::t_cfg_idx idx, stl_pkg::t_ms value);
            case (idx)
                stl_pkg::CFG_OFF_DELAY: off_delay = value;
                stl_pkg::CFG_PASSAGE:   passage = value;
                default: ;
            endcase
        endfunction

        function void start_action(logic on, stl_pkg::t_cat c);
            lit     = on;
            cat     = c;
            elapsed = '0;
        endfunction

        function void note_input(stl_pkg::t_cmd cmd, logic bot, logic top);
            stl_pkg::t_ms     tmo;
            logic             bot_e;
            logic             top_e;
            logic             fired;
            stl_pkg::t_result r;
            fired = 1'b0;
            case (cmd)
                stl_pkg::CMD_TICK: begin
                    bot_e    = bot & ~prev_bot;
                    top_e    = top & ~prev_top;
                    tmo      = (elapsed == stl_pkg::MS_MAX) ? elapsed : elapsed + 32'd1;
                    prev_bot = bot;
                    prev_top = top;
                    elapsed  = tmo;
                    if (!lit) begin
                        if (bot_e) begin
                            start_action(1'b1, stl_pkg::CAT_UP);
                            fired = 1'b1;
                        end else if (top_e) begin
                            start_action(1'b1, stl_pkg::CAT_DOWN);
                            fired = 1'b1;
                        end
                    end else if (tmo > off_delay) begin
                        start_action(1'b0, cat);
                        fired = 1'b1;
                    end else if ((cat == stl_pkg::CAT_DOWN && bot_e) ||
                                 (cat == stl_pkg::CAT_UP && top_e)) begin
                        // passage from the far end: full if quick, else off keeping direction
                        if (tmo < passage) start_action(1'b1, stl_pkg::CAT_FULL);
                        else start_action(1'b0, cat);
                        fired = 1'b1;
                    end else if (bot && (cat == stl_pkg::CAT_FULL || cat == stl_pkg::CAT_UP)) begin
                        elapsed = '0;
                    end else if (top && (cat == stl_pkg::CAT_FULL || cat == stl_pkg::CAT_DOWN)) begin
                        elapsed = '0;
                    end
                end
                stl_pkg::CMD_FORCE_UP: begin
                    start_action(1'b1, stl_pkg::CAT_UP);
                    fired = 1'b1;
                end
                stl_pkg::CMD_FORCE_DN: begin
                    start_action(1'b1, stl_pkg::CAT_DOWN);
                    fired = 1'b1;
                end
                stl_pkg::CMD_FORCE_ALL: begin
                    start_action(1'b1, stl_pkg::CAT_FULL);
                    fired = 1'b1;
                end
                stl_pkg::CMD_FORCE_OFF: begin
                    start_action(1'b0, stl_pkg::CAT_FULL);
                    fired = 1'b1;
                end
                default: ;
            endcase
            r.lights_on    = lit;
            r.direction    = cat;
            r.action_fired = fired;
            pending.push_back(r);
        endfunction

        function void check_result(stl_pkg::t_result got);
            stl_pkg::t_result exp_r;
            if (pending.size() == 0) begin
                $error("result transfer with nothing pending");
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.lights_on !== exp_r.lights_on) begin
                $error("lights_on: expected %0d, got %0d", exp_r.lights_on, got.lights_on);
                errors++;
            end
            if (got.direction !== exp_r.direction) begin
                $error("direction: expected %0d, got %0d", exp_r.direction, got.direction);
                errors++;
            end
            if (got.action_fired !== exp_r.action_fired) begin
                $error("action_fired: expected %0d, got %0d", exp_r.action_fired,
                       got.action_fired);
                errors++;
            end
        endfunction

        function bit empty();
            return pending.size() == 0;
        endfunction

        function void report_leftover();
            if (pending.size() != 0) begin
                $error("results missing: %0d", pending.size());
                errors++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    stl_pkg::t_cmd     i_in_command = stl_pkg::CMD_TICK;
    logic              i_in_bottom_sensor = 1'b0;
    logic              i_in_top_sensor = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic              o_out_lights_on;
    stl_pkg::t_cat     o_out_direction;
    logic              o_out_action_fired;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    stl_pkg::t_cfg_idx i_cfg_index = stl_pkg::CFG_OFF_DELAY;
    stl_pkg::t_ms      i_cfg_data = '0;

    light_scoreboard sb;
    bit              calm;
    bit              long_hold_req;
    int unsigned     cycles;
    logic            bot_lvl;
    logic            top_lvl;
    int unsigned     quiet;

    stair_light_sequencer i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_in_command       (i_in_command),
        .i_in_bottom_sensor (i_in_bottom_sensor),
        .i_in_top_sensor    (i_in_top_sensor),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_out_lights_on    (o_out_lights_on),
        .o_out_direction    (o_out_direction),
        .o_out_action_fired (o_out_action_fired),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(stl_pkg::t_cmd cmd, logic bot, logic top);
        int unsigned gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_in_command       <= cmd;
        i_in_bottom_sensor <= bot;
        i_in_top_sensor    <= top;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(cmd, bot, top);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (!sb.empty());
    endtask

    task automatic write_config(stl_pkg::t_ms off_ms, stl_pkg::t_ms pass_ms);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= stl_pkg::CFG_OFF_DELAY;
        i_cfg_data  <= off_ms;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(stl_pkg::CFG_OFF_DELAY, off_ms);
        i_cfg_index <= stl_pkg::CFG_PASSAGE;
        i_cfg_data  <= pass_ms;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(stl_pkg::CFG_PASSAGE, pass_ms);
        i_cfg_valid <= 1'b0;
    endtask

    // people come and go: short pulses with quiet stretches between
    task automatic next_sensors();
        if (quiet > 0) begin
            quiet--;
            bot_lvl = 1'b0;
            top_lvl = 1'b0;
        end else if ($urandom_range(0, 39) == 0) begin
            quiet   = $urandom_range(5, 60);
            bot_lvl = 1'b0;
            top_lvl = 1'b0;
        end else begin
            if (bot_lvl) bot_lvl = ($urandom_range(0, 2) != 0);
            else bot_lvl = ($urandom_range(0, 9) == 0);
            if (top_lvl) top_lvl = ($urandom_range(0, 2) != 0);
            else top_lvl = ($urandom_range(0, 9) == 0);
        end
    endtask

    task automatic run_phase(stl_pkg::t_ms off_ms, stl_pkg::t_ms pass_ms, int unsigned count);
        int unsigned   sent;
        int unsigned   roll;
        stl_pkg::t_cmd cmd;
        sent = 0;
        write_config(off_ms, pass_ms);
        while (sent < count) begin
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 149) == 0) calm = !calm;
            if (roll < 3) begin
                cmd = stl_pkg::t_cmd'($urandom_range(5, 7));
                send_item(cmd, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else if (roll < 12) begin
                cmd = stl_pkg::t_cmd'($urandom_range(1, 4));
                send_item(cmd, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                sent++;
            end else begin
                next_sensors();
                send_item(stl_pkg::CMD_TICK, bot_lvl, top_lvl);
                sent++;
            end
            if ($urandom_range(0, 199) == 0) drain_results();
        end
        drain_results();
    endtask

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    always @(posedge i_clk) begin
        stl_pkg::t_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.lights_on    = o_out_lights_on;
            got.direction    = o_out_direction;
            got.action_fired = o_out_action_fired;
            sb.check_result(got);
        end
    end

    // receiver side stall pattern, with an occasional long hold-off
    initial begin
        bit          level;
        int unsigned len;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                level         = 1'b1;
                len           = LONG_HOLD;
            end else begin
                level = calm ? 1'b0 : ($urandom_range(0, 2) == 0);
                len   = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 3)
                                                    : $urandom_range(8, 40);
            end
            i_out_stall <= level;
            repeat (len) @(posedge i_clk);
        end
    end

    initial begin
        sb      = new();
        calm    = 1'b0;
        bot_lvl = 1'b0;
        top_lvl = 1'b0;
        quiet   = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at reset settings
        send_item(stl_pkg::t_cmd'(7), 1'b1, 1'b1);
        send_item(stl_pkg::CMD_TICK, 1'b0, 1'b0);
        send_item(stl_pkg::CMD_TICK, 1'b1, 1'b0);
        send_item(stl_pkg::CMD_TICK, 1'b1, 1'b0);
        send_item(stl_pkg::CMD_TICK, 1'b0, 1'b1);
        send_item(stl_pkg::CMD_TICK, 1'b1, 1'b1);
        send_item(stl_pkg::CMD_FORCE_OFF, 1'b0, 1'b0);
        send_item(stl_pkg::CMD_TICK, 1'b0, 1'b0);
        send_item(stl_pkg::CMD_TICK, 1'b0, 1'b1);
        send_item(stl_pkg::CMD_TICK, 1'b1, 1'b1);
        send_item(stl_pkg::CMD_FORCE_UP, 1'b0, 1'b0);
        send_item(stl_pkg::CMD_FORCE_DN, 1'b0, 1'b0);
        send_item(stl_pkg::CMD_FORCE_ALL, 1'b0, 1'b0);
        send_item(stl_pkg::CMD_FORCE_OFF, 1'b0, 1'b0);
        send_item(stl_pkg::t_cmd'(6), 1'b0, 1'b0);
        send_item(stl_pkg::CMD_FORCE_UP, 1'b1, 1'b1);
        send_item(stl_pkg::CMD_TICK, 1'b1, 1'b0);
        drain_results();

        // short timers: late passage goes off, then the off timeout
        write_config(32'd3, 32'd2);
        send_item(stl_pkg::CMD_FORCE_DN, 1'b0, 1'b0);
        send_item(stl_pkg::CMD_TICK, 1'b0, 1'b0);
        send_item(stl_pkg::CMD_TICK, 1'b1, 1'b0);
        send_item(stl_pkg::CMD_FORCE_UP, 1'b0, 1'b0);
        repeat (4) send_item(stl_pkg::CMD_TICK, 1'b0, 1'b0);
        drain_results();

        long_hold_req = 1'b1;
        run_phase(32'd20, 32'd8, PHASE_ITEMS);
        run_phase(32'd0, 32'd0, PHASE_ITEMS);
        run_phase(stl_pkg::MS_MAX, stl_pkg::MS_MAX, PHASE_ITEMS);
        run_phase(stl_pkg::MS_MAX, 32'd0, PHASE_ITEMS);
        long_hold_req = 1'b1;
        run_phase(32'd6, stl_pkg::MS_MAX, PHASE_ITEMS);
        run_phase($urandom_range(0, 80), $urandom_range(0, 50), PHASE_ITEMS);
        run_phase($urandom_range(0, 80), $urandom_range(0, 50), PHASE_ITEMS);
        run_phase(stl_pkg::OFF_DELAY_RST, stl_pkg::PASSAGE_RST, PHASE_ITEMS);

        repeat (10) @(posedge i_clk);
        sb.report_leftover();
        if (sb.errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
